/* design/convex_polygon_point_test_defines.svh */
// Assertion macros for the convex polygon point test checker.
// Expect clk and rst_n in the scope of each use.
`ifndef CONVEX_POLYGON_POINT_TEST_DEFINES_SVH
`define CONVEX_POLYGON_POINT_TEST_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cpt_pkg.sv */
// Shared types, constants and state encoding for the convex polygon point test.
// No dependencies.
package cpt_pkg;

    localparam int COORD_W         = 16;
    localparam int IDX_W           = 4;
    localparam int COUNT_REG_W     = 5;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int MAX_CORNERS_DEF = 16;
    localparam int MIN_CORNERS     = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    localparam logic                   REQ_LOAD         = 1'b0;
    localparam logic                   REQ_QUERY        = 1'b1;
    localparam logic [PADDR_W-3:0]     REG_VERTEX_COUNT = '0;
    localparam logic [COUNT_REG_W-1:0] VERTEX_COUNT_RST = 5'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRIME,
        ST_SETUP,
        ST_DIFF,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DECIDE,
        ST_DONE
    } cpt_state_t;

endpackage

/* design/cpt_req_if.sv */
// Request channel: corner loads and point queries.
// Depends on cpt_pkg.
interface cpt_req_if;
    import cpt_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [IDX_W-1:0] vertex_index;
    coord_t           coord_x;
    coord_t           coord_y;

    modport source (output valid, req_type, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, req_type, vertex_index, coord_x, coord_y, output ready);
endinterface

/* design/cpt_res_if.sv */
// Result channel: one inside flag per point query.
// Depends on cpt_pkg.
interface cpt_res_if;
    import cpt_pkg::*;

    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink   (input valid, inside_res, output ready);
endinterface

/* design/cpt_ram.sv */
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module cpt_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/convex_polygon_point_test.sv */
// Convex polygon point test: corner table in RAM, edge walk on one multiplier.
// Depends on cpt_pkg, cpt_req_if, cpt_res_if and cpt_ram.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    req_type, vertex_index, coord_x, coord_y
//   res      out  valid / ready    inside_res
//   apb      in   psel & penable   paddr, pwdata, prdata (vertex_count at 0x0)
//
// A load is written on its beat and leaves ready high.
// A query holds the block from its beat until its result is loaded, walking edges
// up to the first rejecting edge, at most the corner count: four products
// per edge pass through the single 17x17 multiplier, plus one corner read each.
// A finished result waits in the output register; the block takes the next beat
// meanwhile and stalls only at the end of a later query until res is taken.
// Reset: vertex_count returns to 3; corner RAM contents are kept as they are.
module convex_polygon_point_test #(
    parameter int MAX_CORNERS = cpt_pkg::MAX_CORNERS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    cpt_req_if.sink                      req,
    cpt_res_if.source                    res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpt_pkg::PADDR_W-1:0]  paddr,
    input  logic [cpt_pkg::PDATA_W-1:0]  pwdata,
    output logic [cpt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import cpt_pkg::*;

    localparam int AW = $clog2(MAX_CORNERS);
    localparam int CW = $clog2(MAX_CORNERS + 1);

    cpt_state_t             state_reg, state_next;
    logic [COUNT_REG_W-1:0] vertex_count_reg, vertex_count_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [CW-1:0]          edge_cnt_reg, edge_cnt_next;
    logic [1:0]             prime_cnt_reg, prime_cnt_next;
    logic [AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic                   rd_pending_reg, rd_pending_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   res_inside_reg;

    coord_t px_reg, py_reg;
    coord_t s_x_reg, s_y_reg, e_x_reg, e_y_reg, t_x_reg, t_y_reg;
    diff_t  a_reg, b_reg, dtx_reg, dty_reg, dpx_reg, dpy_reg;
    prod_t  prod_reg, acc_reg;
    logic   flip_reg;

    logic                 req_beat, query_beat, load_we, cfg_write;
    logic [CW-1:0]        count_clamped;
    logic [AW-1:0]        rd_ptr_inc;
    logic                 last_edge, outside, res_load;
    diff_t                mul_a, mul_b;
    sum_t                 sum_w;
    logic [2*COORD_W-1:0] ram_rdata;

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT)
                       ? PDATA_W'(vertex_count_reg) : '0;

    always_comb
    begin
        int vc;
        vc = int'(vertex_count_reg);
        if (vc < MIN_CORNERS)
        begin
            vc = MIN_CORNERS;
        end
        if (vc > MAX_CORNERS)
        begin
            vc = MAX_CORNERS;
        end
        count_clamped = CW'(vc);
    end

    assign req_beat   = req.valid && req.ready;
    assign query_beat = req_beat && (req.req_type == REQ_QUERY);
    assign load_we    = req_beat && (req.req_type == REQ_LOAD)
                        && (int'(req.vertex_index) < MAX_CORNERS);

    cpt_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_CORNERS)
    ) u_corner_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(req.vertex_index)),
        .wdata ({req.coord_x, req.coord_y}),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign rd_ptr_inc = ((CW'(rd_ptr_reg) + CW'(1)) == n_reg) ? '0 : rd_ptr_reg + AW'(1);
    assign last_edge  = (edge_cnt_reg + CW'(1)) == n_reg;
    assign sum_w      = sum_t'(acc_reg) + sum_t'(prod_reg);
    assign outside    = flip_reg ? sum_w[SUM_W-1] : (!sum_w[SUM_W-1] && (sum_w != '0));

    always_comb
    begin
        case (state_reg)
            ST_MUL0:
            begin
                mul_a = a_reg;
                mul_b = dtx_reg;
            end
            ST_MUL1:
            begin
                mul_a = b_reg;
                mul_b = dty_reg;
            end
            ST_MUL2:
            begin
                mul_a = a_reg;
                mul_b = dpx_reg;
            end
            default:
            begin
                mul_a = b_reg;
                mul_b = dpy_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_beat)
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                if (prime_cnt_reg == 2'd2)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:  state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MUL0;
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_MUL3;
            ST_MUL3:   state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                state_next = (outside || last_edge) ? ST_DONE : ST_DIFF;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and control updates
    always_comb
    begin
        req.ready         = (state_reg == ST_IDLE);
        res.valid         = res_valid_reg;
        res.inside_res    = res_inside_reg;
        res_load          = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);
        vertex_count_next = cfg_write ? pwdata[COUNT_REG_W-1:0] : vertex_count_reg;
        n_next            = query_beat ? count_clamped : n_reg;
        rd_pending_next   = (state_reg == ST_PRIME) || (state_reg == ST_DIFF);
        prime_cnt_next    = prime_cnt_reg;
        rd_ptr_next       = rd_ptr_reg;
        edge_cnt_next     = edge_cnt_reg;
        if (query_beat)
        begin
            prime_cnt_next = '0;
            rd_ptr_next    = '0;
            edge_cnt_next  = '0;
        end
        if (state_reg == ST_PRIME)
        begin
            prime_cnt_next = prime_cnt_reg + 2'd1;
        end
        if (rd_pending_next)
        begin
            rd_ptr_next = rd_ptr_inc;
        end
        if ((state_reg == ST_DECIDE) && !outside && !last_edge)
        begin
            edge_cnt_next = edge_cnt_reg + CW'(1);
        end
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            vertex_count_reg <= VERTEX_COUNT_RST;
            n_reg            <= CW'(MIN_CORNERS);
            edge_cnt_reg     <= '0;
            prime_cnt_reg    <= '0;
            rd_ptr_reg       <= '0;
            rd_pending_reg   <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            vertex_count_reg <= vertex_count_next;
            n_reg            <= n_next;
            edge_cnt_reg     <= edge_cnt_next;
            prime_cnt_reg    <= prime_cnt_next;
            rd_ptr_reg       <= rd_ptr_next;
            rd_pending_reg   <= rd_pending_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (query_beat)
        begin
            px_reg <= req.coord_x;
            py_reg <= req.coord_y;
        end
        // advance the corner window
        if (rd_pending_reg)
        begin
            s_x_reg <= e_x_reg;
            s_y_reg <= e_y_reg;
            e_x_reg <= t_x_reg;
            e_y_reg <= t_y_reg;
            t_x_reg <= ram_rdata[2*COORD_W-1:COORD_W];
            t_y_reg <= ram_rdata[COORD_W-1:0];
        end
        if (state_reg == ST_DIFF)
        begin
            a_reg   <= diff_t'(e_y_reg) - diff_t'(s_y_reg);
            b_reg   <= diff_t'(s_x_reg) - diff_t'(e_x_reg);
            dtx_reg <= diff_t'(t_x_reg) - diff_t'(s_x_reg);
            dty_reg <= diff_t'(t_y_reg) - diff_t'(s_y_reg);
            dpx_reg <= diff_t'(px_reg) - diff_t'(s_x_reg);
            dpy_reg <= diff_t'(py_reg) - diff_t'(s_y_reg);
        end
        prod_reg <= prod_t'(mul_a) * prod_t'(mul_b);
        if ((state_reg == ST_MUL1) || (state_reg == ST_MUL3))
        begin
            acc_reg <= prod_reg;
        end
        if (state_reg == ST_MUL2)
        begin
            flip_reg <= !sum_w[SUM_W-1] && (sum_w != '0);
        end
        if (res_load)
        begin
            res_inside_reg <= !outside;
        end
    end

endmodule

/* design/cpt_checker.sv */
// Port-level checks for the convex polygon point test, bound to the top level.
// Depends on convex_polygon_point_test_defines.svh and cpt_pkg.
`include "convex_polygon_point_test_defines.svh"

module cpt_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_type,
    input logic res_valid,
    input logic res_ready
);
    import cpt_pkg::*;

    `CPT_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result beat dropped before taken")
    `CPT_ASSERT_NXT(a_query_busy, req_valid && req_ready && (req_type == REQ_QUERY), !req_ready, "ready stayed high after a query beat")
    `CPT_ASSERT_NXT(a_load_fast, req_valid && req_ready && (req_type == REQ_LOAD), req_ready, "load beat did not complete in one cycle")
    `CPT_ASSERT_IMP(a_res_after_busy, $rose(res_valid), $past(!req_ready), "result appeared without a query in flight")

endmodule

bind convex_polygon_point_test cpt_checker u_cpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .res_valid (res.valid),
    .res_ready (res.ready)
);

/* tb/tb_top.sv */
// Testbench for convex_polygon_point_test: fills the corner table, sweeps vertex counts
// and checks each point-query answer against an in-bench half-plane predictor.
// Depends on cpt_pkg, cpt_req_if, cpt_res_if and the convex_polygon_point_test top level.
module tb_top;
    import cpt_pkg::*;

    localparam int  HOLDOFF_CYCLES = 400;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  LOAD_SETTLE    = 4;
    localparam int  END_SETTLE     = 120;
    localparam int  RANDOM_PHASES  = 20;
    localparam int  MAX_PRINTS     = 50;
    localparam real TWO_PI         = 6.283185307179586;

    typedef enum int {
        SHAPE_CONVEX,
        SHAPE_SCATTER,
        SHAPE_DUPLICATE,
        SHAPE_COLLINEAR
    } shape_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cpt_req_if req_ch();
    cpt_res_if res_ch();

    convex_polygon_point_test i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    coord_t                 corner_x_tbl [MAX_CORNERS_DEF];
    coord_t                 corner_y_tbl [MAX_CORNERS_DEF];
    logic [COUNT_REG_W-1:0] count_reg = VERTEX_COUNT_RST;
    bit                     inside_expected_q [$];

    int mismatch_count;
    int loads_sent;
    int queries_sent;
    int inside_seen;
    int outside_seen;
    int settings_used;
    int holdoff_request;
    bit idle_on;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int corners_in_use();
        if (count_reg < MIN_CORNERS)
            return MIN_CORNERS;
        if (count_reg > MAX_CORNERS_DEF)
            return MAX_CORNERS_DEF;
        return count_reg;
    endfunction

    function automatic bit predict_inside(input coord_t px, input coord_t py);
        int     n;
        int     j;
        int     k;
        longint sx;
        longint sy;
        longint kx;
        longint ky;
        longint a;
        longint b;
        longint c;
        n = corners_in_use();
        for (int i = 0; i < n; i++)
        begin
            j  = (i + 1) % n;
            k  = (i + 2) % n;
            sx = corner_x_tbl[i];
            sy = corner_y_tbl[i];
            kx = corner_x_tbl[k];
            ky = corner_y_tbl[k];
            a  = longint'(corner_y_tbl[j]) - sy;
            b  = sx - longint'(corner_x_tbl[j]);
            c  = -(a * sx + b * sy);
            // orient the line so the rest of the polygon is on its non-positive side
            if (a * kx + b * ky + c > 0)
            begin
                a = -a;
                b = -b;
                c = -c;
            end
            if (a * longint'(px) + b * longint'(py) + c > 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic coord_t clamp_coord(input int v);
        if (v < -32768)
            return coord_t'(-32768);
        if (v > 32767)
            return coord_t'(32767);
        return coord_t'(v);
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic send_item(input logic kind, input logic [IDX_W-1:0] slot,
                             input coord_t x, input coord_t y);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.vertex_index <= slot;
        req_ch.coord_x      <= x;
        req_ch.coord_y      <= y;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (kind == REQ_LOAD)
        begin
            corner_x_tbl[slot] = x;
            corner_y_tbl[slot] = y;
            loads_sent++;
        end
        else
        begin
            inside_expected_q.insert(inside_expected_q.size(), predict_inside(x, y));
            queries_sent++;
        end
    endtask

    task automatic load_corner(input int slot, input int x, input int y);
        send_item(REQ_LOAD, IDX_W'(slot), coord_t'(x), coord_t'(y));
    endtask

    task automatic query_point(input int x, input int y);
        send_item(REQ_QUERY, IDX_W'($urandom_range(0, MAX_CORNERS_DEF - 1)),
                  coord_t'(x), coord_t'(y));
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (inside_expected_q.size() != 0)
            @(posedge clk);
        // hold for a trailing corner load
        repeat (LOAD_SETTLE) @(posedge clk);
    endtask

    task automatic set_vertex_count(input int count);
        logic [PDATA_W-1:0]     wdata;
        logic [COUNT_REG_W-1:0] value;
        value                  = COUNT_REG_W'(count);
        wdata                  = $urandom();
        wdata[COUNT_REG_W-1:0] = value;
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_VERTEX_COUNT, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        count_reg = value;
        settings_used++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(PDATA_W - COUNT_REG_W){1'b0}}, value})
            report_mismatch($sformatf("vertex_count read back 0x%0h, wrote %0d", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_polygon(input int n, input shape_t shape);
        int  xs [MAX_CORNERS_DEF];
        int  ys [MAX_CORNERS_DEF];
        int  radius;
        int  lim;
        int  cx;
        int  cy;
        int  dx;
        int  dy;
        int  dup;
        real turn;
        real ang;
        radius = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 512)
                                              : $urandom_range(512, 32000);
        lim    = 32767 - radius;
        cx     = int'($urandom_range(0, 2 * lim)) - lim;
        cy     = int'($urandom_range(0, 2 * lim)) - lim;
        dx     = int'($urandom_range(0, 64)) - 32;
        dy     = int'($urandom_range(0, 64)) - 32;
        turn   = ($urandom_range(0, 1) == 1) ? 1.0 : -1.0;
        for (int i = 0; i < n; i++)
        begin
            case (shape)
                SHAPE_SCATTER:
                begin
                    xs[i] = coord_t'($urandom());
                    ys[i] = coord_t'($urandom());
                end
                SHAPE_COLLINEAR:
                begin
                    xs[i] = cx + i * dx;
                    ys[i] = cy + i * dy;
                end
                default:
                begin
                    ang   = turn * TWO_PI * (i + $urandom_range(0, 800) / 1000.0) / n;
                    xs[i] = cx + $rtoi(radius * $cos(ang));
                    ys[i] = cy + $rtoi(radius * $sin(ang));
                end
            endcase
        end
        if (shape == SHAPE_DUPLICATE)
        begin
            dup = $urandom_range(0, n - 1);
            xs[(dup + 1) % n] = xs[dup];
            ys[(dup + 1) % n] = ys[dup];
        end
        for (int i = 0; i < n; i++)
            load_corner(i, clamp_coord(xs[i]), clamp_coord(ys[i]));
    endtask

    task automatic query_near_polygon(input int n);
        int xmin;
        int xmax;
        int ymin;
        int ymax;
        int i;
        int j;
        int qx;
        int qy;
        int pick;
        xmin = corner_x_tbl[0];
        xmax = xmin;
        ymin = corner_y_tbl[0];
        ymax = ymin;
        for (int m = 1; m < n; m++)
        begin
            if (corner_x_tbl[m] < xmin) xmin = corner_x_tbl[m];
            if (corner_x_tbl[m] > xmax) xmax = corner_x_tbl[m];
            if (corner_y_tbl[m] < ymin) ymin = corner_y_tbl[m];
            if (corner_y_tbl[m] > ymax) ymax = corner_y_tbl[m];
        end
        i    = $urandom_range(0, n - 1);
        j    = (i + 1) % n;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            qx = xmin + int'($urandom_range(0, xmax - xmin));
            qy = ymin + int'($urandom_range(0, ymax - ymin));
        end
        else if (pick < 50)
        begin
            qx = corner_x_tbl[i];
            qy = corner_y_tbl[i];
        end
        else if (pick < 75)
        begin
            qx = (int'(corner_x_tbl[i]) + int'(corner_x_tbl[j])) >>> 1;
            qy = (int'(corner_y_tbl[i]) + int'(corner_y_tbl[j])) >>> 1;
            // nudge off the edge by one LSB
            if (pick >= 65)
            begin
                if ($urandom_range(0, 1) == 1)
                    qx = qx + (($urandom_range(0, 1) == 1) ? 1 : -1);
                else
                    qy = qy + (($urandom_range(0, 1) == 1) ? 1 : -1);
            end
        end
        else if (pick < 90)
        begin
            qx = coord_t'($urandom());
            qy = coord_t'($urandom());
        end
        else
        begin
            qx = extreme_coord();
            qy = extreme_coord();
        end
        query_point(clamp_coord(qx), clamp_coord(qy));
    endtask

    task automatic test_extreme_square();
        set_vertex_count(4);
        load_corner(0, -32768, -32768);
        load_corner(1,  32767, -32768);
        load_corner(2,  32767,  32767);
        load_corner(3, -32768,  32767);
        query_point(0, 0);
        query_point(32767, 32767);
        query_point(-32768, 0);
        query_point(0, 32767);
        query_point(-32768, -32768);
    endtask

    task automatic test_degenerate_edge();
        load_corner(3, 32767, 32767);
        query_point(16, -16);
        query_point(-16, 16);
        query_point(32767, 32767);
    endtask

    task automatic test_collinear_corners();
        set_vertex_count(3);
        load_corner(0, 0, 0);
        load_corner(1, 160, 160);
        load_corner(2, -320, -320);
        query_point(80, 80);
        query_point(80, 96);
        query_point(-32768, -32768);
    endtask

    task automatic test_count_clamp();
        set_vertex_count(0);
        query_point(80, 80);
        query_point(1, 0);
    endtask

    task automatic test_backpressure();
        int sx;
        int sy;
        idle_on = 1'b0;
        set_vertex_count(16);
        load_polygon(16, SHAPE_CONVEX);
        sx = 0;
        sy = 0;
        for (int i = 0; i < 16; i++)
        begin
            sx += corner_x_tbl[i];
            sy += corner_y_tbl[i];
        end
        // stall the result side while central points keep the edge walk long
        holdoff_request = HOLDOFF_CYCLES;
        for (int q = 0; q < 8; q++)
            query_point(clamp_coord(sx / 16), clamp_coord(sy / 16));
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_random_polygons();
        logic [COUNT_REG_W-1:0] fixed_counts [10] = '{3, 16, 0, 31, 1, 2, 17, 4, 15, 8};
        logic [COUNT_REG_W-1:0] setting;
        shape_t                 shape;
        int                     n;
        int                     queries;
        int                     roll;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_on = (p < RANDOM_PHASES - 3) && ($urandom_range(0, 3) != 0);
            setting = (p < 10) ? fixed_counts[p] : COUNT_REG_W'($urandom_range(0, 31));
            set_vertex_count(setting);
            n    = corners_in_use();
            roll = $urandom_range(0, 99);
            if (roll < 70)
                shape = SHAPE_CONVEX;
            else if (roll < 82)
                shape = SHAPE_SCATTER;
            else if (roll < 94)
                shape = SHAPE_DUPLICATE;
            else
                shape = SHAPE_COLLINEAR;
            load_polygon(n, shape);
            queries = $urandom_range(24, 36);
            for (int q = 0; q < queries; q++)
            begin
                if (p % 4 == 1 && q == queries / 2)
                    drain_results();
                if ($urandom_range(0, 11) == 0)
                begin
                    if (n < MAX_CORNERS_DEF && $urandom_range(0, 3) != 0)
                        load_corner($urandom_range(n, MAX_CORNERS_DEF - 1),
                                    coord_t'($urandom()), coord_t'($urandom()));
                    else
                        load_corner($urandom_range(0, MAX_CORNERS_DEF - 1),
                                    coord_t'($urandom()), coord_t'($urandom()));
                end
                else
                    query_near_polygon(n);
            end
        end
    endtask

    initial
    begin
        int burst;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (holdoff_request > 0)
            begin
                burst           = holdoff_request;
                holdoff_request = 0;
                res_ch.ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 9);
                res_ch.ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        bit expected;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (res_ch.inside_res)
                    inside_seen++;
                else
                    outside_seen++;
                if (inside_expected_q.size() == 0)
                    report_mismatch("inside_res beat with no query outstanding");
                else
                begin
                    expected = inside_expected_q.pop_front();
                    if (res_ch.inside_res !== expected)
                        report_mismatch($sformatf("inside_res %b, expected %b",
                                                  res_ch.inside_res, expected));
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** convex_polygon_point_test: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_LOAD;
        req_ch.vertex_index <= '0;
        req_ch.coord_x      <= '0;
        req_ch.coord_y      <= '0;
        idle_on = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_square();
        test_degenerate_edge();
        test_collinear_corners();
        test_count_clamp();
        test_backpressure();
        test_random_polygons();

        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (inside_expected_q.size() != 0)
            report_mismatch($sformatf("%0d query answers never arrived",
                                      inside_expected_q.size()));
        $display("Run covered %0d corner loads and %0d point queries (%0d inside, %0d outside),",
                 loads_sent, queries_sent, inside_seen, outside_seen);
        $display("across %0d vertex_count writes, with %0d mismatches.",
                 settings_used, mismatch_count);
        if (mismatch_count == 0)
            $display("** convex_polygon_point_test: PASSED **");
        else
            $display("** convex_polygon_point_test: FAILED **");
        $finish;
    end

endmodule
